// File: rtl/core/weighted_window_distance_macros.svh
// Assertion helpers for the window distance back end.
// Both expect clk and rst in scope; checks are off while rst is high.
`ifndef WEIGHTED_WINDOW_DISTANCE_MACROS_SVH
`define WEIGHTED_WINDOW_DISTANCE_MACROS_SVH

// Same-cycle implication
`define WWD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wwd_pkg.sv
`timescale 1ns / 1ps

package wwd_pkg;

  localparam int RAD_W  = 3;
  localparam int POS_W  = 4;
  localparam int OFF_W  = 3;
  localparam int CH_W   = 8;
  localparam int SQ_W   = 18;
  localparam int W_W    = 16;
  localparam int PROD_W = SQ_W + W_W;
  localparam int DIST_W = 45;

  localparam logic [DIST_W-1:0] DIST_MAX     = '1;
  localparam logic [RAD_W-1:0]  RADIUS_RESET = 3'd2;

  // Element classification done by the front end
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SKIP   = 2'd0;
  localparam kind_t KIND_REJECT = 2'd1;
  localparam kind_t KIND_ACC    = 2'd2;

  typedef struct packed {
    kind_t            kind;
    logic             last;
    logic [SQ_W-1:0]  sq;
    logic [RAD_W-1:0] radius;
    logic [OFF_W-1:0] off_lo;
    logic [OFF_W-1:0] off_hi;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef struct packed {
    logic              is_candidate;
    logic [DIST_W-1:0] distance;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

// File: rtl/core/wwd_fifo.sv
`timescale 1ns / 1ps

module wwd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store item
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

// File: rtl/core/wwd_front.sv
`timescale 1ns / 1ps

module wwd_front import wwd_pkg::*; #(
  parameter int MAX_RADIUS = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [RAD_W-1:0] cfg_radius,
  input  logic             accept,
  input  logic [CH_W-1:0]  tmpl_red,
  input  logic [CH_W-1:0]  tmpl_green,
  input  logic [CH_W-1:0]  tmpl_blue,
  input  logic             tmpl_set,
  input  logic [CH_W-1:0]  cand_red,
  input  logic [CH_W-1:0]  cand_green,
  input  logic [CH_W-1:0]  cand_blue,
  input  logic             cand_set,
  output cmd_t             cmd
);

  localparam int MAX_EFF = (MAX_RADIUS < 7) ? MAX_RADIUS : 7;
  localparam logic [RAD_W-1:0] RAD_TOP = RAD_W'(MAX_EFF);

  function automatic logic [RAD_W-1:0] clamp_radius(input logic [RAD_W-1:0] v);
    if (v == '0) return RAD_W'(1);
    else if (v > RAD_TOP) return RAD_TOP;
    else return v;
  endfunction

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [RAD_W-1:0]  radius;
  logic [POS_W-1:0]  row;
  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  centre_pos;
  logic [POS_W-1:0]  end_pos;
  logic              at_centre;
  logic              at_last;
  logic [POS_W-1:0]  dr;
  logic [POS_W-1:0]  dc;
  logic [CH_W-1:0]   d_red;
  logic [CH_W-1:0]   d_green;
  logic [CH_W-1:0]   d_blue;
  logic [2*CH_W-1:0] sq_red;
  logic [2*CH_W-1:0] sq_green;
  logic [2*CH_W-1:0] sq_blue;

  assign centre_pos = POS_W'(radius);
  assign end_pos    = {radius, 1'b0};
  assign at_centre  = (row == centre_pos) && (col == centre_pos);
  assign at_last    = (row == end_pos) && (col == end_pos);

  // Offsets from the window centre
  assign dr = (row >= centre_pos) ? (row - centre_pos) : (centre_pos - row);
  assign dc = (col >= centre_pos) ? (col - centre_pos) : (centre_pos - col);

  // Squared RGB difference
  assign d_red    = abs_diff(tmpl_red, cand_red);
  assign d_green  = abs_diff(tmpl_green, cand_green);
  assign d_blue   = abs_diff(tmpl_blue, cand_blue);
  assign sq_red   = d_red * d_red;
  assign sq_green = d_green * d_green;
  assign sq_blue  = d_blue * d_blue;

  // Classify element
  always_comb begin
    cmd.last   = at_last;
    cmd.sq     = SQ_W'(sq_red) + SQ_W'(sq_green) + SQ_W'(sq_blue);
    cmd.radius = radius;
    if (dr <= dc) begin
      cmd.off_lo = dr[OFF_W-1:0];
      cmd.off_hi = dc[OFF_W-1:0];
    end else begin
      cmd.off_lo = dc[OFF_W-1:0];
      cmd.off_hi = dr[OFF_W-1:0];
    end
    priority if (at_centre || !tmpl_set) cmd.kind = KIND_SKIP;
    else if (!cand_set)                  cmd.kind = KIND_REJECT;
    else                                 cmd.kind = KIND_ACC;
  end

  // Track row-major position inside the window
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= clamp_radius(RADIUS_RESET);
      row    <= '0;
      col    <= '0;
    end else if (cfg_we) begin
      radius <= clamp_radius(cfg_radius);
      row    <= '0;
      col    <= '0;
    end else if (accept) begin
      if (at_last) begin
        row <= '0;
        col <= '0;
      end else if (col == end_pos) begin
        row <= row + POS_W'(1);
        col <= '0;
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/wwd_back.sv
`timescale 1ns / 1ps

module wwd_back import wwd_pkg::*; #(
  parameter int MAX_RADIUS = 7
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  cmd_t    cmd,
  input  logic    cmd_valid,
  output logic    cmd_pop,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  localparam int MAX_EFF = (MAX_RADIUS < 7) ? MAX_RADIUS : 7;
  localparam int PAIRS   = (MAX_EFF + 1) * (MAX_EFF + 2) / 2;
  localparam int ENTRIES = MAX_EFF * PAIRS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [63:0] Q32_ONE    = 64'h1_0000_0000;
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

  // Restoring division, used only while building the weight table
  function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Gaussian weight in Q0.16, sigma = len / 6.4
  function automatic logic [W_W-1:0] gauss_weight(input logic [63:0] d2,
                                                  input logic [63:0] len);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] val;
    logic [63:0] w;
    longint      sum;
    num  = 64'd512 * d2;
    den  = 64'd25 * len * len;
    q    = cdiv(num, den);
    r    = num - q * den;
    term = Q32_ONE;
    sum  = longint'(Q32_ONE);
    for (int k = 1; k <= 24; k++) begin
      term = cdiv(term * r, den * 64'(k));
      if ((k & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    val = (sum > 0) ? 64'(sum) : 64'd0;
    for (int k = 0; k < 16; k++) begin
      if (64'(k) < q) val = (val * EXP_M1_Q32 + 64'h8000_0000) >> 32;
    end
    w = (val + 64'h8000) >> 16;
    if (w > 64'd65535) w = 64'd65535;
    return w[W_W-1:0];
  endfunction

  // One entry per radius and unordered offset pair (lo <= hi <= radius)
  function automatic logic [ENTRIES*W_W-1:0] build_weights();
    logic [ENTRIES*W_W-1:0] t;
    t = '0;
    for (int rad = 1; rad <= MAX_EFF; rad++) begin
      for (int hi = 0; hi <= rad; hi++) begin
        for (int lo = 0; lo <= hi; lo++) begin
          t[((rad - 1) * PAIRS + hi * (hi + 1) / 2 + lo) * W_W +: W_W] =
            gauss_weight(64'(lo * lo + hi * hi), 64'(2 * rad + 1));
        end
      end
    end
    return t;
  endfunction

  localparam logic [ENTRIES*W_W-1:0] WEIGHTS = build_weights();

  logic              s1_valid;
  kind_t             s1_kind;
  logic              s1_last;
  logic [SQ_W-1:0]   s1_sq;
  logic [W_W-1:0]    s1_weight;
  logic              s2_valid;
  kind_t             s2_kind;
  logic              s2_last;
  logic [PROD_W-1:0] s2_prod;
  logic [DIST_W-1:0] acc;
  logic              rejected;

  logic              s2_done;
  logic              s2_can;
  logic              s1_move;
  logic              s1_can;
  logic [5:0]        hi_tri;
  logic [31:0]       idx_full;
  logic [IDX_W-1:0]  idx;
  logic [DIST_W:0]   acc_sum;
  logic [DIST_W-1:0] acc_next;
  logic              rejected_next;

  // Pipeline flow: only a window result can stall the last stage
  assign s2_done = s2_valid && (!s2_last || !res_full);
  assign s2_can  = !s2_valid || s2_done;
  assign s1_move = s1_valid && s2_can;
  assign s1_can  = !s1_valid || s1_move;
  assign cmd_pop = cmd_valid && s1_can;

  // Weight table address
  assign hi_tri   = (6'(cmd.off_hi) * (6'(cmd.off_hi) + 6'd1)) >> 1;
  assign idx_full = 32'(cmd.radius - RAD_W'(1)) * 32'(PAIRS) + 32'(hi_tri)
                  + 32'(cmd.off_lo);
  assign idx      = idx_full[IDX_W-1:0];

  // Stage 1: look up weight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_can) begin
      s1_valid <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_kind   <= cmd.kind;
      s1_last   <= cmd.last;
      s1_sq     <= cmd.sq;
      s1_weight <= WEIGHTS[idx * W_W +: W_W];
    end
  end

  // Stage 2: weight the squared difference
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_can) begin
      s2_valid <= s1_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_kind <= s1_kind;
      s2_last <= s1_last;
      s2_prod <= PROD_W'(s1_sq) * PROD_W'(s1_weight);
    end
  end

  // Saturating accumulate and reject tracking
  assign acc_sum = {1'b0, acc} + (DIST_W + 1)'(s2_prod);

  always_comb begin
    acc_next      = acc;
    rejected_next = rejected;
    unique case (s2_kind)
      KIND_ACC:    acc_next = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
      KIND_REJECT: rejected_next = 1'b1;
      default:     acc_next = acc;
    endcase
  end

  assign res_push         = s2_done && s2_last;
  assign res.is_candidate = !rejected_next;
  assign res.distance     = rejected_next ? '0 : acc_next;

  // Hold window state; clear on result or register write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      acc      <= '0;
      rejected <= 1'b0;
    end else if (s2_done) begin
      if (s2_last) begin
        acc      <= '0;
        rejected <= 1'b0;
      end else begin
        acc      <= acc_next;
        rejected <= rejected_next;
      end
    end
  end

`include "weighted_window_distance_macros.svh"

  `WWD_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_move, s1_valid, "stage 1 item dropped")
  `WWD_ASSERT_NEXT(a_s2_hold, s2_valid && !s2_done, s2_valid && s2_last, "stalled result lost")
  `WWD_ASSERT_NEXT(a_window_clear, res_push, acc == '0 && !rejected, "window not cleared")
  `WWD_ASSERT_IMPLIES(a_acc_no_wrap, s2_done && s2_kind == KIND_ACC, acc_next >= acc, "accumulator wrapped")

endmodule

// File: rtl/core/weighted_window_distance.sv
`timescale 1ns / 1ps
// Gaussian weighted SSD between a template window and a candidate window.
// Input queue side: push/full. One item is one window element (template and
// candidate RGB plus their set flags), sent in row-major order, side
// 2*radius+1. Accepted when push is high and full is low.
// Result queue side: empty/pop. One result per window, after its last
// element: distance (Q29.16 weighted sum, saturating) and is_candidate.
// Configuration: cfg_valid/cfg_ready with window_radius as data; cfg_ready
// is always high. A write sets the radius and restarts the window; write
// only while no element is in flight. Radius 0 acts as 1.
// Throughput: one element per cycle, set by the single accumulator update
// in the back end, while the result queue takes results. The last element
// passes stage 1 and stage 2; its result then shows with empty low.
// A stalled receiver holds results in a two-entry output queue; the back
// end then stops at the next window end and the four-entry command queue
// fills, raising full.
// Reset: radius 2, window position, sum and reject flag cleared, queues empty.

module weighted_window_distance import wwd_pkg::*; #(
  parameter int MAX_RADIUS = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RAD_W-1:0]  window_radius,
  input  logic              push,
  output logic              full,
  input  logic [CH_W-1:0]   tmpl_red,
  input  logic [CH_W-1:0]   tmpl_green,
  input  logic [CH_W-1:0]   tmpl_blue,
  input  logic              tmpl_set,
  input  logic [CH_W-1:0]   cand_red,
  input  logic [CH_W-1:0]   cand_green,
  input  logic [CH_W-1:0]   cand_blue,
  input  logic              cand_set,
  output logic              empty,
  input  logic              pop,
  output logic [DIST_W-1:0] distance,
  output logic              is_candidate
);

  logic    cfg_we;
  logic    accept;
  cmd_t    front_cmd;
  cmd_t    mid_cmd;
  logic    mid_empty;
  logic    mid_pop;
  logic    res_push;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = push && !full;

  wwd_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_radius (window_radius),
    .accept     (accept),
    .tmpl_red   (tmpl_red),
    .tmpl_green (tmpl_green),
    .tmpl_blue  (tmpl_blue),
    .tmpl_set   (tmpl_set),
    .cand_red   (cand_red),
    .cand_green (cand_green),
    .cand_blue  (cand_blue),
    .cand_set   (cand_set),
    .cmd        (front_cmd)
  );

  wwd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (4)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_cmd),
    .empty (mid_empty)
  );

  wwd_back #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cmd       (mid_cmd),
    .cmd_valid (!mid_empty),
    .cmd_pop   (mid_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  wwd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign distance     = res_out.distance;
  assign is_candidate = res_out.is_candidate;

endmodule
